// File: rtl/tta_pkg.sv
`timescale 1ns / 1ps
// tta_pkg: widths, codes, register types and the arctangent table of the
// trunk tilt alarm. No dependencies.
package tta_pkg;

	localparam int COORD_WIDTH = 16;

	// trunk difference (hips - 2*neck) and its magnitude
	localparam int DIFF_W = COORD_WIDTH + 2;
	localparam int MAG_W = COORD_WIDTH + 1;

	// magnitudes are scaled down until all are below 2^NORM_SHIFT
	localparam int NORM_SHIFT = 20;
	localparam int NW = (MAG_W < NORM_SHIFT) ? MAG_W : NORM_SHIFT;
	localparam int PROD_W = 2 * NW;
	localparam int SUM_W = 2 * NW + 1;

	// square root of (ax^2 + az^2) * 2^16, radicand padded to an even width
	localparam int SQ_FRAC = 16;
	localparam int SQ_N_W = SUM_W + SQ_FRAC + 1;
	localparam int ROOT_W = SQ_N_W / 2;
	localparam int REM_W = ROOT_W + 3;
	localparam int SQ_CNT_W = $clog2(ROOT_W + 1);

	// vertical component is scaled by 2^8 before the cordic
	localparam int VERT_SHIFT = 8;

	localparam int CR_W = ROOT_W + 3;
	localparam int CORDIC_STEPS = 17;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int ANG_W = 20;
	localparam int ANG_SHIFT = 8;
	localparam int ROUND_HALF = 128;

	localparam int TILT_W = 10;
	localparam int CNT_W = 8;
	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [TILT_W-1:0] TILT_MAX = 10'd900;

	localparam logic [TILT_W-1:0] RST_TILT_LIMIT = 10'd300;
	localparam logic [CNT_W-1:0] RST_HOLD_FRAMES = 8'd30;
	localparam logic [CNT_W-1:0] RST_COOLDOWN_FRAMES = 8'd30;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_FRAMES = 2'd2;

	typedef struct packed {
		logic [TILT_W-1:0] tilt_limit;
		logic [CNT_W-1:0] hold_frames;
		logic [CNT_W-1:0] cooldown_frames;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_MUL_X,
		ST_MUL_Z,
		ST_SUM,
		ST_SQRT,
		ST_CORDIC,
		ST_FINISH
	} state_t;

	// atan(2^-i) in units of 1/2560 degree
	function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
		logic signed [ANG_W-1:0] a;
		case (i)
			5'd0: a = ANG_W'(115200);
			5'd1: a = ANG_W'(68007);
			5'd2: a = ANG_W'(35933);
			5'd3: a = ANG_W'(18240);
			5'd4: a = ANG_W'(9155);
			5'd5: a = ANG_W'(4582);
			5'd6: a = ANG_W'(2292);
			5'd7: a = ANG_W'(1146);
			5'd8: a = ANG_W'(573);
			5'd9: a = ANG_W'(286);
			5'd10: a = ANG_W'(143);
			5'd11: a = ANG_W'(72);
			5'd12: a = ANG_W'(36);
			5'd13: a = ANG_W'(18);
			5'd14: a = ANG_W'(9);
			5'd15: a = ANG_W'(4);
			5'd16: a = ANG_W'(2);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/tta_sqrt.sv
`timescale 1ns / 1ps
// tta_sqrt: digit-by-digit integer square root, one result bit per cycle.
// Depends on tta_pkg.
module tta_sqrt import tta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_N_W-1:0] radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_N_W-1:0] n_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic fits;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_q[REM_W-3:0], n_q[SQ_N_W-1 -: 2]};
	assign trial = REM_W'({root_q, 2'b01});
	assign fits = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= SQ_CNT_W'(ROOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQ_CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (run_q) begin
			n_q <= n_q << 2;
			rem_q <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/tta_cordic.sv
`timescale 1ns / 1ps
// tta_cordic: vectoring cordic, one rotation per cycle on a shared
// add/subtract and shift unit, ending in a rounded, clamped tilt. Uses tta_pkg.
module tta_cordic import tta_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [CR_W-1:0] x0,
	input  logic signed [CR_W-1:0] y0,
	output logic                   done,
	output logic [TILT_W-1:0]      tilt
);

	logic signed [CR_W-1:0] cx_q;
	logic signed [CR_W-1:0] cy_q;
	logic signed [ANG_W-1:0] ang_q;
	logic [STEP_W-1:0] i_q;
	logic run_q;
	logic done_q;

	logic signed [CR_W-1:0] sx;
	logic signed [CR_W-1:0] sy;
	logic y_pos;
	logic signed [ANG_W-1:0] a_i;
	logic signed [ANG_W-1:0] rnd;
	logic signed [ANG_W-1:0] t_full;

	assign sx = cx_q >>> i_q;
	assign sy = cy_q >>> i_q;
	assign y_pos = !cy_q[CR_W-1] && (cy_q != '0);
	assign a_i = atan_step(i_q);

	// round to tenths of a degree, then clamp to 0..900
	assign rnd = ang_q + ANG_W'(ROUND_HALF);
	assign t_full = rnd >>> ANG_SHIFT;

	always_comb begin
		if (t_full[ANG_W-1])
			tilt = '0;
		else if ($unsigned(t_full) > ANG_W'(TILT_MAX))
			tilt = TILT_MAX;
		else
			tilt = t_full[TILT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q <= '0;
			end else if (run_q) begin
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q <= x0;
			cy_q <= y0;
			ang_q <= '0;
		end else if (run_q) begin
			if (y_pos) begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				ang_q <= ang_q + a_i;
			end else begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				ang_q <= ang_q - a_i;
			end
		end
	end

	assign done = done_q;

endmodule

// File: rtl/tta_alarm.sv
`timescale 1ns / 1ps
// tta_alarm: hold and cooldown counters plus the output register.
// Depends on tta_pkg.
module tta_alarm import tta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              ok,
	input  logic [TILT_W-1:0] tilt,
	input  cfg_t              cfg,
	input  logic              out_stall,
	output logic              free,
	output logic              out_valid,
	output logic              angle_valid,
	output logic [TILT_W-1:0] tilt_angle,
	output logic              alarm,
	output logic              cooling_down
);

	logic [CNT_W-1:0] tc_q;
	logic [CNT_W-1:0] cd_q;
	logic ov_q;
	logic av_q;
	logic [TILT_W-1:0] ta_q;
	logic al_q;
	logic cdo_q;

	logic [CNT_W-1:0] tc_inc;
	logic [CNT_W-1:0] tc_n;
	logic [CNT_W-1:0] cd_n;
	logic alarm_n;

	// saturating at all ones
	assign tc_inc = (tc_q == '1) ? tc_q : tc_q + 1'b1;

	always_comb begin
		tc_n = tc_q;
		cd_n = cd_q;
		alarm_n = 1'b0;
		if (ok) begin
			if (cd_q == '0) begin
				if (tilt > cfg.tilt_limit) begin
					tc_n = tc_inc;
					if (tc_inc >= cfg.hold_frames) begin
						alarm_n = 1'b1;
						cd_n = CNT_W'(1);
					end
				end else begin
					tc_n = '0;
				end
			end else if (cd_q >= cfg.cooldown_frames) begin
				cd_n = '0;
				tc_n = '0;
			end else begin
				cd_n = cd_q + 1'b1;
			end
		end
	end

	assign free = !ov_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			cd_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				tc_q <= tc_n;
				cd_q <= cd_n;
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			av_q <= ok;
			ta_q <= ok ? tilt : '0;
			al_q <= alarm_n;
			cdo_q <= (cd_n != '0);
		end
	end

	assign out_valid = ov_q;
	assign angle_valid = av_q;
	assign tilt_angle = ta_q;
	assign alarm = al_q;
	assign cooling_down = cdo_q;

endmodule

// File: rtl/trunk_tilt_alarm.sv
`timescale 1ns / 1ps
// trunk_tilt_alarm: top level; configuration registers, sequencer, shared
// multiplier. Uses tta_pkg, tta_sqrt, tta_cordic and tta_alarm.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------
//  in      | in_valid / in_stall         | neck, hip coordinates, joint ok bits
//  out     | out_valid / out_stall       | angle_valid, tilt_angle, alarm,
//          |                             | cooling_down
//  cfg     | cfg_wr_en, cfg_index        | cfg_data
//
// A frame with all joints valid passes the normalizing shifts, the squares of
// x and z, their sum, the square root bit loop and the cordic rotation loop;
// the two loops set its time. A zero, vertical or horizontal trunk skips the
// cordic. A frame with an invalid joint goes from idle straight to the finish
// state. in_stall is high from accept until the beat
// is in the output register; that register frees the input while a result
// waits on out_stall. Reset clears counters and loads register defaults.
module trunk_tilt_alarm import tta_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] neck_x,
	input  logic signed [COORD_WIDTH-1:0] neck_y,
	input  logic signed [COORD_WIDTH-1:0] neck_z,
	input  logic signed [COORD_WIDTH-1:0] left_hip_x,
	input  logic signed [COORD_WIDTH-1:0] left_hip_y,
	input  logic signed [COORD_WIDTH-1:0] left_hip_z,
	input  logic signed [COORD_WIDTH-1:0] right_hip_x,
	input  logic signed [COORD_WIDTH-1:0] right_hip_y,
	input  logic signed [COORD_WIDTH-1:0] right_hip_z,
	input  logic                          neck_ok,
	input  logic                          left_hip_ok,
	input  logic                          right_hip_ok,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          angle_valid,
	output logic [TILT_W-1:0]             tilt_angle,
	output logic                          alarm,
	output logic                          cooling_down,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	cfg_t cfg_q;
	state_t state_q;
	state_t state_n;

	logic [MAG_W-1:0] mx_q;
	logic [MAG_W-1:0] my_q;
	logic [MAG_W-1:0] mz_q;
	logic ok_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] acc_q;
	logic [TILT_W-1:0] tilt_q;

	logic in_ok;
	logic accept;
	logic [MAG_W-1:0] ax;
	logic [MAG_W-1:0] ay;
	logic [MAG_W-1:0] az;
	logic norm_big;
	logic [NW-1:0] mul_op;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0] sum;
	logic [SQ_N_W-1:0] radicand;
	logic sq_start;
	logic sq_done;
	logic [ROOT_W-1:0] sq_root;
	logic cr_start;
	logic cr_done;
	logic [TILT_W-1:0] cr_tilt;
	logic signed [CR_W-1:0] cr_x0;
	logic signed [CR_W-1:0] cr_y0;
	logic fin_load;
	logic out_free;

	function automatic logic [MAG_W-1:0] trunk_mag(
		input logic signed [COORD_WIDTH-1:0] l,
		input logic signed [COORD_WIDTH-1:0] r,
		input logic signed [COORD_WIDTH-1:0] n
	);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'(l) + DIFF_W'(r) - (DIFF_W'(n) <<< 1);
		return d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tilt_limit <= RST_TILT_LIMIT;
			cfg_q.hold_frames <= RST_HOLD_FRAMES;
			cfg_q.cooldown_frames <= RST_COOLDOWN_FRAMES;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TILT_LIMIT: cfg_q.tilt_limit <= cfg_data[TILT_W-1:0];
				REG_HOLD_FRAMES: cfg_q.hold_frames <= cfg_data[CNT_W-1:0];
				REG_COOLDOWN_FRAMES: cfg_q.cooldown_frames <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ok = neck_ok & left_hip_ok & right_hip_ok;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && (state_q == ST_IDLE);

	assign ax = trunk_mag(left_hip_x, right_hip_x, neck_x);
	assign ay = trunk_mag(left_hip_y, right_hip_y, neck_y);
	assign az = trunk_mag(left_hip_z, right_hip_z, neck_z);

	assign norm_big = ((mx_q >> NORM_SHIFT) != '0) || ((my_q >> NORM_SHIFT) != '0)
		|| ((mz_q >> NORM_SHIFT) != '0);

	// one multiplier squares x, then z
	assign mul_op = (state_q == ST_MUL_Z) ? mz_q[NW-1:0] : mx_q[NW-1:0];
	assign prod = mul_op * mul_op;
	assign sum = SUM_W'(acc_q) + SUM_W'(prod_q);
	assign radicand = {1'b0, sum, {SQ_FRAC{1'b0}}};

	assign cr_x0 = signed'(CR_W'({my_q[NW-1:0], {VERT_SHIFT{1'b0}}}));
	assign cr_y0 = signed'(CR_W'(sq_root));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		sq_start = 1'b0;
		cr_start = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_n = in_ok ? ST_NORM : ST_FINISH;
			end
			ST_NORM: begin
				if (!norm_big)
					state_n = ST_MUL_X;
			end
			ST_MUL_X: state_n = ST_MUL_Z;
			ST_MUL_Z: state_n = ST_SUM;
			ST_SUM: begin
				sq_start = 1'b1;
				state_n = ST_SQRT;
			end
			ST_SQRT: begin
				if (sq_done) begin
					if (sq_root == '0 || my_q == '0) begin
						state_n = ST_FINISH;
					end else begin
						cr_start = 1'b1;
						state_n = ST_CORDIC;
					end
				end
			end
			ST_CORDIC: begin
				if (cr_done)
					state_n = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					fin_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mx_q <= ax;
			my_q <= ay;
			mz_q <= az;
			ok_q <= in_ok;
			tilt_q <= '0;
		end
		if (state_q == ST_NORM && norm_big) begin
			mx_q <= mx_q >> 1;
			my_q <= my_q >> 1;
			mz_q <= mz_q >> 1;
		end
		if (state_q == ST_MUL_X || state_q == ST_MUL_Z)
			prod_q <= prod;
		if (state_q == ST_MUL_Z)
			acc_q <= prod_q;
		// zero or vertical vector stays 0, horizontal vector is a full 90 degrees
		if (state_q == ST_SQRT && sq_done)
			tilt_q <= (sq_root == '0) ? '0 : TILT_MAX;
		if (state_q == ST_CORDIC && cr_done)
			tilt_q <= cr_tilt;
	end

	tta_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (sq_root)
	);

	tta_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cr_start),
		.x0     (cr_x0),
		.y0     (cr_y0),
		.done   (cr_done),
		.tilt   (cr_tilt)
	);

	tta_alarm u_alarm (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fin_load),
		.ok           (ok_q),
		.tilt         (tilt_q),
		.cfg          (cfg_q),
		.out_stall    (out_stall),
		.free         (out_free),
		.out_valid    (out_valid),
		.angle_valid  (angle_valid),
		.tilt_angle   (tilt_angle),
		.alarm        (alarm),
		.cooling_down (cooling_down)
	);

endmodule

// File: rtl/tta_checker.sv
`timescale 1ns / 1ps
// tta_checker: port-level assertions for trunk_tilt_alarm, attached by bind.
// Depends on tta_pkg and the top level's port names.
module tta_checker import tta_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              angle_valid,
	input logic [TILT_W-1:0] tilt_angle,
	input logic              alarm,
	input logic              cooling_down
);

	// one frame at a time: an accepted beat makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a frame is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tilt_angle) && $stable(alarm)
			&& $stable(angle_valid) && $stable(cooling_down))
		else $error("stalled result beat changed");

	// an alarm frame always starts the cooldown
	a_alarm_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alarm |-> angle_valid && cooling_down)
		else $error("alarm without valid angle or cooldown");

	a_invalid_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !angle_valid |-> tilt_angle == '0 && !alarm)
		else $error("invalid frame reported an angle or alarm");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tilt_angle <= TILT_MAX)
		else $error("tilt above 90 degrees");

endmodule

bind trunk_tilt_alarm tta_checker u_tta_checker (.*);
